/* design/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and keyword constants for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int TOKEN_MAX_DEFAULT = 16;
    localparam int LINE_MAX_DEFAULT  = 128;

    localparam int WORD_CNT_W = 6;
    localparam int TAIL_CNT_W = 8;
    localparam int KW_COUNT   = 8;
    localparam int KW_CHARS   = 8;

    localparam logic [1:0] ROLE_SKIP = 2'd0;
    localparam logic [1:0] ROLE_CMD  = 2'd1;
    localparam logic [1:0] ROLE_ARG  = 2'd2;
    localparam logic [1:0] ROLE_END  = 2'd3;

    localparam logic [3:0] KIND_EMPTY    = 4'd0;
    localparam logic [3:0] KIND_DIR      = 4'd1;
    localparam logic [3:0] KIND_TYPE     = 4'd2;
    localparam logic [3:0] KIND_CD       = 4'd3;
    localparam logic [3:0] KIND_CLS      = 4'd4;
    localparam logic [3:0] KIND_VER      = 4'd5;
    localparam logic [3:0] KIND_ECHO     = 4'd6;
    localparam logic [3:0] KIND_EXIT     = 4'd7;
    localparam logic [3:0] KIND_EXTERNAL = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
        '{"D", "I", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "Y", "P", "E",   8'h00, 8'h00, 8'h00, 8'h00},
        '{"C", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"C", "H", "D", "I",   "R",   8'h00, 8'h00, 8'h00},
        '{"C", "L", "S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"V", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "C", "H", "O",   8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "X", "I", "T",   8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [WORD_CNT_W-1:0] KW_LEN [KW_COUNT] = '{
        6'd3, 6'd4, 6'd2, 6'd5, 6'd3, 6'd3, 6'd4, 6'd4
    };

    localparam logic [3:0] KW_KIND [KW_COUNT] = '{
        KIND_DIR, KIND_TYPE, KIND_CD, KIND_CD, KIND_CLS, KIND_VER, KIND_ECHO, KIND_EXIT
    };

    typedef struct packed {
        logic [1:0]            role;
        logic [7:0]            out_char;
        logic [7:0]            position;
        logic [3:0]            kind;
        logic [WORD_CNT_W-1:0] command_length;
        logic [TAIL_CNT_W-1:0] argument_length;
    } clt_result_t;

endpackage

/* design/clt_kw_match.sv */
// ----------------------------------------------------------------------------
// clt_kw_match
// Keyword candidate narrowing and end-of-line command kind selection.
// ----------------------------------------------------------------------------
module clt_kw_match (
    input  logic [clt_pkg::WORD_CNT_W-1:0] word_count,
    input  logic [7:0]                     upper_char,
    input  logic [clt_pkg::KW_COUNT-1:0]   alive,
    output logic [clt_pkg::KW_COUNT-1:0]   alive_next,
    output logic [3:0]                     kind
);

    always_comb begin
        alive_next = alive;
        for (int k = 0; k < clt_pkg::KW_COUNT; k++) begin
            if (word_count >= clt_pkg::KW_LEN[k]) begin
                alive_next[k] = 1'b0;
            end else if (clt_pkg::KW_TEXT[k][word_count[2:0]] != upper_char) begin
                alive_next[k] = 1'b0;
            end
        end
    end

    always_comb begin
        kind = clt_pkg::KIND_EXTERNAL;
        for (int k = clt_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (alive[k] && (clt_pkg::KW_LEN[k] == word_count)) begin
                kind = clt_pkg::KW_KIND[k];
            end
        end
        if (word_count == '0) begin
            kind = clt_pkg::KIND_EMPTY;
        end
    end

endmodule

/* design/clt_step.sv */
// ----------------------------------------------------------------------------
// clt_step
// Line state registers and per-byte phase logic of the tokenizer.
// ----------------------------------------------------------------------------
module clt_step #(
    parameter int TOKEN_MAX = clt_pkg::TOKEN_MAX_DEFAULT,
    parameter int LINE_MAX  = clt_pkg::LINE_MAX_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           ch,
    output clt_pkg::clt_result_t result
);

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_WORD = 3'd1;
    localparam logic [2:0] PH_DROP = 3'd2;
    localparam logic [2:0] PH_GAP  = 3'd3;
    localparam logic [2:0] PH_ARG  = 3'd4;

    localparam logic [clt_pkg::WORD_CNT_W-1:0] WORD_LIMIT =
        clt_pkg::WORD_CNT_W'(TOKEN_MAX - 1);
    localparam logic [clt_pkg::TAIL_CNT_W-1:0] TAIL_LIMIT =
        clt_pkg::TAIL_CNT_W'(LINE_MAX - 1);

    logic [2:0]                       phase_reg;
    logic [2:0]                       phase_next;
    logic [clt_pkg::WORD_CNT_W-1:0]   word_count_reg;
    logic [clt_pkg::WORD_CNT_W-1:0]   word_count_next;
    logic [clt_pkg::TAIL_CNT_W-1:0]   tail_count_reg;
    logic [clt_pkg::TAIL_CNT_W-1:0]   tail_count_next;
    logic [clt_pkg::KW_COUNT-1:0]     alive_reg;
    logic [clt_pkg::KW_COUNT-1:0]     alive_next;
    logic [clt_pkg::KW_COUNT-1:0]     alive_narrowed;
    logic [3:0]                       kind;
    logic [7:0]                       upper_char;
    logic                             ws;

    assign ws = (ch == clt_pkg::CH_SPACE) || (ch == clt_pkg::CH_TAB);
    assign upper_char = ((ch >= clt_pkg::CH_LOW_A) && (ch <= clt_pkg::CH_LOW_Z)) ?
                        (ch - clt_pkg::CASE_OFS) : ch;

    clt_kw_match u_kw_match (
        .word_count (word_count_reg),
        .upper_char (upper_char),
        .alive      (alive_reg),
        .alive_next (alive_narrowed),
        .kind       (kind)
    );

    always_comb begin
        phase_next      = phase_reg;
        word_count_next = word_count_reg;
        tail_count_next = tail_count_reg;
        alive_next      = alive_reg;
        result          = '0;

        if (ch == clt_pkg::CH_NUL) begin
            result.role            = clt_pkg::ROLE_END;
            result.kind            = kind;
            result.command_length  = word_count_reg;
            result.argument_length = tail_count_reg;
            phase_next             = PH_LEAD;
            word_count_next        = '0;
            tail_count_next        = '0;
            alive_next             = '1;
        end else begin
            if ((phase_reg == PH_LEAD) && !ws) begin
                phase_next = PH_WORD;
            end

            if (phase_next == PH_WORD) begin
                if (ws) begin
                    phase_next = PH_GAP;
                end else if (word_count_reg < WORD_LIMIT) begin
                    result.role     = clt_pkg::ROLE_CMD;
                    result.out_char = upper_char;
                    result.position = 8'(word_count_reg);
                    alive_next      = alive_narrowed;
                    word_count_next = word_count_reg + 1'b1;
                end else begin
                    phase_next = PH_DROP;
                end
            end else if (phase_next == PH_DROP) begin
                if (ws) begin
                    phase_next = PH_GAP;
                end
            end else if (phase_next == PH_GAP) begin
                if (!ws) begin
                    phase_next = PH_ARG;
                end
            end else if ((phase_next != PH_ARG) && (phase_next != PH_LEAD)) begin
                phase_next      = PH_LEAD;
                word_count_next = '0;
                tail_count_next = '0;
                alive_next      = '1;
            end

            if ((phase_next == PH_ARG) && (result.role == clt_pkg::ROLE_SKIP)) begin
                if (tail_count_reg < TAIL_LIMIT) begin
                    result.role     = clt_pkg::ROLE_ARG;
                    result.out_char = ch;
                    result.position = tail_count_reg;
                    tail_count_next = tail_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEAD;
            word_count_reg <= '0;
            tail_count_reg <= '0;
            alive_reg      <= '1;
        end else if (advance) begin
            phase_reg      <= phase_next;
            word_count_reg <= word_count_next;
            tail_count_reg <= tail_count_next;
            alive_reg      <= alive_next;
        end
    end

endmodule

/* design/command_line_tokenize_classify_unit.sv */
// ----------------------------------------------------------------------------
// command_line_tokenize_classify_unit
// Byte-stream command line tokenizer with keyword classification.
// ----------------------------------------------------------------------------
// Input channel s_*: one line byte per transaction on s_ch; a zero byte ends
// the line. Result channel m_*: exactly one result transaction per input
// transaction, in order: role, emitted character and its position, and at
// the end of a line the command kind and the stored word and argument lengths.
// Each accepted transaction is captured in the input register, passes through
// the phase logic into the result register and is then offered on m_valid.
// Throughput: one transaction per cycle while m_ready stays high, set by the
// single registered pass through the phase logic and line state in clt_step.
// An input register and a result register part the two sides, so s_ready
// stays high while a finished result waits; when the receiver holds m_ready
// low, both registers fill and s_ready drops until the result is taken.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// line state to the start of a new line.
// ----------------------------------------------------------------------------
module command_line_tokenize_classify_unit #(
    parameter int TOKEN_MAX = clt_pkg::TOKEN_MAX_DEFAULT,
    parameter int LINE_MAX  = clt_pkg::LINE_MAX_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_ch,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_role,
    output logic [7:0]                         m_out_char,
    output logic [7:0]                         m_position,
    output logic [3:0]                         m_kind,
    output logic [clt_pkg::WORD_CNT_W-1:0]     m_command_length,
    output logic [clt_pkg::TAIL_CNT_W-1:0]     m_argument_length
);

    logic                 in_valid_reg;
    logic [7:0]           ch_reg;
    logic                 out_valid_reg;
    clt_pkg::clt_result_t result_reg;
    clt_pkg::clt_result_t step_result;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    clt_step #(
        .TOKEN_MAX (TOKEN_MAX),
        .LINE_MAX  (LINE_MAX)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ch      (ch_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_role            = result_reg.role;
    assign m_out_char        = result_reg.out_char;
    assign m_position        = result_reg.position;
    assign m_kind            = result_reg.kind;
    assign m_command_length  = result_reg.command_length;
    assign m_argument_length = result_reg.argument_length;

endmodule

/* verif/line_token_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_token_checker
// Predicts and checks every result transaction of the command line tokenizer.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted input byte runs through a behavioral
// copy of the tokenizer phases and keyword matching, and its expected result
// is queued. Each accepted result is compared field by field with the oldest
// queued expectation. Mismatches, and results with nothing queued, are counted.
// ----------------------------------------------------------------------------
module line_token_checker #(
    parameter int TOKEN_MAX = clt_pkg::TOKEN_MAX_DEFAULT,
    parameter int LINE_MAX  = clt_pkg::LINE_MAX_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [7:0]                     s_ch,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [1:0]                     m_role,
    input  logic [7:0]                     m_out_char,
    input  logic [7:0]                     m_position,
    input  logic [3:0]                     m_kind,
    input  logic [clt_pkg::WORD_CNT_W-1:0] m_command_length,
    input  logic [clt_pkg::TAIL_CNT_W-1:0] m_argument_length,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             lines_seen,
    output logic [8:0]                     kinds_seen
);

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_WORD = 3'd1;
    localparam logic [2:0] PH_DROP = 3'd2;
    localparam logic [2:0] PH_GAP  = 3'd3;
    localparam logic [2:0] PH_ARG  = 3'd4;

    logic [2:0]                     phase;
    logic [clt_pkg::WORD_CNT_W-1:0] word_len;
    logic [clt_pkg::TAIL_CNT_W-1:0] arg_len;
    logic [clt_pkg::KW_COUNT-1:0]   kw_alive;

    clt_pkg::clt_result_t expected_q [$];
    clt_pkg::clt_result_t prediction;
    clt_pkg::clt_result_t oldest;
    clt_pkg::clt_result_t observed;

    initial begin
        phase        = PH_LEAD;
        word_len     = '0;
        arg_len      = '0;
        kw_alive     = '1;
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        lines_seen   = 0;
        kinds_seen   = '0;
    end

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        fail_count++;
        $display("%0t ns result %0d: %s, expected 0x%0h got 0x%0h",
                 $time, results_seen, what, want, got);
    endtask

    function automatic logic [3:0] line_kind();
        int k;
        if (word_len == 0)
            return clt_pkg::KIND_EMPTY;
        for (k = 0; k < clt_pkg::KW_COUNT; k++) begin
            if (kw_alive[k] && clt_pkg::KW_LEN[k] == word_len)
                return clt_pkg::KW_KIND[k];
        end
        return clt_pkg::KIND_EXTERNAL;
    endfunction

    task automatic tokenize_byte(input logic [7:0] c, output clt_pkg::clt_result_t r);
        logic       ws;
        logic [7:0] up;
        int         k;
        ws = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
        r  = '0;
        if (c == clt_pkg::CH_NUL) begin
            r.role            = clt_pkg::ROLE_END;
            r.kind            = line_kind();
            r.command_length  = word_len;
            r.argument_length = arg_len;
            phase    = PH_LEAD;
            word_len = '0;
            arg_len  = '0;
            kw_alive = '1;
        end else begin
            if (phase == PH_LEAD && !ws)
                phase = PH_WORD;
            case (phase)
                PH_WORD: begin
                    if (ws) begin
                        phase = PH_GAP;
                    end else if (word_len < TOKEN_MAX - 1) begin
                        up = (c >= clt_pkg::CH_LOW_A && c <= clt_pkg::CH_LOW_Z) ?
                             c - clt_pkg::CASE_OFS : c;
                        for (k = 0; k < clt_pkg::KW_COUNT; k++) begin
                            if (word_len >= clt_pkg::KW_LEN[k])
                                kw_alive[k] = 1'b0;
                            else if (clt_pkg::KW_TEXT[k][word_len] != up)
                                kw_alive[k] = 1'b0;
                        end
                        r.role     = clt_pkg::ROLE_CMD;
                        r.out_char = up;
                        r.position = 8'(word_len);
                        word_len   = word_len + 1'b1;
                    end else begin
                        phase = PH_DROP;
                    end
                end
                PH_DROP: begin
                    if (ws)
                        phase = PH_GAP;
                end
                PH_GAP: begin
                    if (!ws)
                        phase = PH_ARG;
                end
                default: ;
            endcase
            if (phase == PH_ARG && r.role == clt_pkg::ROLE_SKIP && arg_len < LINE_MAX - 1) begin
                r.role     = clt_pkg::ROLE_ARG;
                r.out_char = c;
                r.position = 8'(arg_len);
                arg_len    = arg_len + 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tokenize_byte(s_ch, prediction);
                expected_q.push_back(prediction);
            end
            if (m_valid && m_ready) begin
                observed.role            = m_role;
                observed.out_char        = m_out_char;
                observed.position        = m_position;
                observed.kind            = m_kind;
                observed.command_length  = m_command_length;
                observed.argument_length = m_argument_length;
                results_seen++;
                if (expected_q.size() == 0) begin
                    report("transaction with nothing expected", 0, observed.role);
                end else begin
                    oldest = expected_q.pop_front();
                    if (observed.role != oldest.role)
                        report("role", oldest.role, observed.role);
                    if (observed.out_char != oldest.out_char)
                        report("out_char", oldest.out_char, observed.out_char);
                    if (observed.position != oldest.position)
                        report("position", oldest.position, observed.position);
                    if (observed.kind != oldest.kind)
                        report("kind", oldest.kind, observed.kind);
                    if (observed.command_length != oldest.command_length)
                        report("command_length", oldest.command_length,
                               observed.command_length);
                    if (observed.argument_length != oldest.argument_length)
                        report("argument_length", oldest.argument_length,
                               observed.argument_length);
                    if (oldest.role == clt_pkg::ROLE_END) begin
                        lines_seen++;
                        kinds_seen[oldest.kind] = 1'b1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the command line tokenizer.
// ----------------------------------------------------------------------------
// Sends a few hand-picked lines (empty line, leading blanks with mixed case,
// a keyword alias with high bytes, an overlong word), then random lines:
// keywords in random case, keyword prefixes and extensions, short and
// overlong words, short and overlong arguments, blank-only lines and raw
// noise. Both channels idle at random, with calm stretches, and the sender
// now and then holds until all results are back. line_token_checker predicts
// and compares; this module reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TOKEN_MAX    = clt_pkg::TOKEN_MAX_DEFAULT;
    localparam int LINE_MAX     = clt_pkg::LINE_MAX_DEFAULT;
    localparam int RANDOM_BYTES = 1300;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic [7:0]                     s_ch    = 8'h00;
    logic                           m_ready = 1'b1;
    logic                           s_ready;
    logic                           m_valid;
    logic [1:0]                     m_role;
    logic [7:0]                     m_out_char;
    logic [7:0]                     m_position;
    logic [3:0]                     m_kind;
    logic [clt_pkg::WORD_CNT_W-1:0] m_command_length;
    logic [clt_pkg::TAIL_CNT_W-1:0] m_argument_length;

    int         fail_count;
    int         pending;
    int         results_seen;
    int         lines_seen;
    logic [8:0] kinds_seen;

    int         bytes_sent = 0;
    int         stall_left = 0;
    bit         calm       = 1'b0;
    logic [7:0] line_q [$];

    always #5 aclk = ~aclk;

    command_line_tokenize_classify_unit #(
        .TOKEN_MAX (TOKEN_MAX),
        .LINE_MAX  (LINE_MAX)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ch              (s_ch),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_role            (m_role),
        .m_out_char        (m_out_char),
        .m_position        (m_position),
        .m_kind            (m_kind),
        .m_command_length  (m_command_length),
        .m_argument_length (m_argument_length)
    );

    line_token_checker #(
        .TOKEN_MAX (TOKEN_MAX),
        .LINE_MAX  (LINE_MAX)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ch              (s_ch),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_role            (m_role),
        .m_out_char        (m_out_char),
        .m_position        (m_position),
        .m_kind            (m_kind),
        .m_command_length  (m_command_length),
        .m_argument_length (m_argument_length),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_seen      (results_seen),
        .lines_seen        (lines_seen),
        .kinds_seen        (kinds_seen)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_ws();
        return $urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] rand_glyph();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB);
        return c;
    endfunction

    function automatic logic [7:0] rand_content();
        if ($urandom_range(0, 4) == 0)
            return rand_ws();
        return 8'($urandom_range(1, 255));
    endfunction

    // receiver: mostly ready, random stalls
    always @(posedge aclk) begin
        if (calm || stall_left == 0) begin
            m_ready <= 1'b1;
            stall_left = calm ? 0 : idle_len();
        end else begin
            m_ready <= 1'b0;
            stall_left--;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    // hold the sender until every queued result has been taken
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    initial begin
        int         shape;
        int         pick;
        int         k;
        int         i;
        int         n;
        int         start_count;
        logic [7:0] c;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        line_q.delete();
        line_q.push_back(clt_pkg::CH_NUL);
        push_text("\t dIr");
        line_q.push_back(clt_pkg::CH_NUL);
        push_text("ChDiR\t");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(clt_pkg::CH_NUL);
        push_text("echoabcdefghijkl z");
        line_q.push_back(clt_pkg::CH_NUL);
        send_line();
        wait_drain();

        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 14) == 0)
                wait_drain();
            line_q.delete();
            shape = $urandom_range(0, 99);
            if (shape < 8) begin
                repeat ($urandom_range(1, 12))
                    line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) line_q.push_back(rand_ws());
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    k = $urandom_range(0, clt_pkg::KW_COUNT - 1);
                    for (i = 0; i < clt_pkg::KW_LEN[k]; i++) begin
                        c = clt_pkg::KW_TEXT[k][i];
                        if ($urandom_range(0, 1))
                            c = c + clt_pkg::CASE_OFS;
                        line_q.push_back(c);
                    end
                    // bend the keyword into a prefix or an extension
                    n = $urandom_range(0, 9);
                    if (n == 0)
                        void'(line_q.pop_back());
                    else if (n == 1)
                        line_q.push_back(rand_glyph());
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 6)) line_q.push_back(rand_glyph());
                end else if (pick < 95) begin
                    repeat ($urandom_range(TOKEN_MAX - 3, TOKEN_MAX + 6))
                        line_q.push_back(rand_glyph());
                end
                if (pick < 95 && $urandom_range(0, 3) != 0) begin
                    repeat ($urandom_range(1, 3)) line_q.push_back(rand_ws());
                    n = ($urandom_range(0, 15) == 0) ?
                        $urandom_range(LINE_MAX - 8, LINE_MAX + 8) : $urandom_range(0, 12);
                    repeat (n) line_q.push_back(rand_content());
                end
            end
            line_q.push_back(clt_pkg::CH_NUL);
            send_line();
        end

        calm = 1'b0;
        wait_drain();
        repeat (8) @(posedge aclk);

        $display("run covered %0d bytes in %0d lines, %0d results checked",
                 bytes_sent, lines_seen, results_seen);
        $display("line kinds reached, external down to empty: %b", kinds_seen);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
design/clt_pkg.sv
design/clt_kw_match.sv
design/clt_step.sv
design/command_line_tokenize_classify_unit.sv
verif/line_token_checker.sv
verif/tb_top.sv
